// ===== design/fir16_pkg.sv =====
// Shared types and codes for the 16-bit FIR filter unit.
package fir16_pkg;

   typedef logic signed [15:0] sample_type;
   typedef logic signed [31:0] acc_type;

   // request function codes
   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_SAMPLE = 2'd1,
      FUNC_START  = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_HOLD
   } state_type;

   // per-cell control from the top level
   typedef struct packed {
      logic shift;
      logic coef_we;
      logic tap_on;
   } ctrl_type;

   // partial sum travelling down the chain, with its marker
   typedef struct packed {
      logic    tok;
      acc_type sum;
   } link_type;

endpackage

// ===== design/fir16_cell.sv =====
// One tap of the FIR chain: history sample, coefficient and partial-sum stage.
module fir16_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  fir16_pkg::ctrl_type   ctrl,
   input  fir16_pkg::sample_type sample_in,
   input  fir16_pkg::sample_type coef_value,
   input  fir16_pkg::link_type   link_in,
   output fir16_pkg::sample_type sample_out,
   output fir16_pkg::link_type   link_out
);
   import fir16_pkg::*;

   sample_type sample_ff;
   sample_type coef_ff;
   acc_type    sum_ff;
   acc_type    sum_in;
   acc_type    prod;
   logic       tok_ff;

   assign prod   = acc_type'(sample_ff) * acc_type'(coef_ff);
   // taps beyond the active count add nothing (also masks unloaded coefficients)
   assign sum_in = ctrl.tap_on ? (link_in.sum + prod) : link_in.sum;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         sample_ff <= sample_in;
      end
      if (ctrl.coef_we) begin
         coef_ff <= coef_value;
      end
      sum_ff <= sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= 1'b0;
      end else begin
         tok_ff <= link_in.tok;
      end
   end

   assign sample_out   = sample_ff;
   assign link_out.tok = tok_ff;
   assign link_out.sum = sum_ff;

endmodule

// ===== design/fir_filter_int16_unit.sv =====
// Top level of the 16-bit direct-form FIR filter unit.
//
// Direct-form FIR for signed 16-bit samples, up to MAX_TAP_COUNT taps, built
// as a row of tap cells. Each cell holds one history sample and one
// coefficient; a sample item shifts the whole history one cell along. When
// the item completes warm-up, a partial sum is launched through launch_ff
// into cell 0 and moves one cell per cycle, each active cell adding its
// product; when it leaves the chain it is loaded into the output register,
// or kept in hold_ff while a waiting result is stalled. Requests are stalled
// during that sweep and hold; coefficient loads, block starts and warm-up
// samples do not stall and are accepted while a result waits in the
// output register. tap_count (csr port, always ready) should only be written
// while the unit is idle; 0 acts as 1, values above MAX_TAP_COUNT as the
// maximum. filter_out and block_sum wrap modulo 2^32; a start item clears the
// sample count and block_sum but keeps history and coefficients.
module fir_filter_int16_unit #(
   parameter int MAX_TAP_COUNT = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_func,
   input  logic [4:0]           req_coef_index,
   input  fir16_pkg::sample_type req_coef_value,
   input  fir16_pkg::sample_type req_sample_in,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fir16_pkg::acc_type    rsp_filter_out,
   output fir16_pkg::acc_type    rsp_block_sum,
   // tap_count register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [5:0]           csr_data
);
   import fir16_pkg::*;

   localparam int CW = $clog2(MAX_TAP_COUNT + 1);

   state_type  state_ff, state_in;
   logic [5:0] tap_count_ff;
   logic [CW-1:0] fill_ff, fill_in, taps_eff;
   logic       launch_ff;
   acc_type    hold_ff;
   acc_type    output_sum_ff, output_sum_in;
   logic       rsp_valid_ff, rsp_valid_in;
   acc_type    filter_out_ff, block_sum_ff;

   logic       accept, acc_sample, acc_start, acc_load, emit;
   logic       slot_free, chain_tok, load_out;
   acc_type    acc_sel;

   ctrl_type   cell_ctrl [MAX_TAP_COUNT];
   sample_type smp [MAX_TAP_COUNT+1];
   link_type   link [MAX_TAP_COUNT+1];

   assign accept     = req_valid && !req_stall;
   assign acc_sample = accept && (req_func == FUNC_SAMPLE);
   assign acc_start  = accept && (req_func == FUNC_START);
   assign acc_load   = accept && (req_func == FUNC_LOAD);
   assign csr_ready  = 1'b1;

   // clamp tap count into 1..MAX
   always_comb begin
      if (tap_count_ff == 6'd0) begin
         taps_eff = CW'(1);
      end else if (32'(tap_count_ff) > 32'(MAX_TAP_COUNT)) begin
         taps_eff = CW'(MAX_TAP_COUNT);
      end else begin
         taps_eff = CW'(tap_count_ff);
      end
   end

   // sample count, saturating at the chain length
   always_comb begin
      fill_in = fill_ff;
      if (acc_start) begin
         fill_in = '0;
      end else if (acc_sample && (32'(fill_ff) < 32'(MAX_TAP_COUNT))) begin
         fill_in = fill_ff + CW'(1);
      end
   end

   assign emit = acc_sample && (fill_in >= taps_eff);

   // ---- tap chain ----
   assign smp[0]      = req_sample_in;
   assign link[0].tok = launch_ff;
   assign link[0].sum = '0;

   for (genvar g = 0; g < MAX_TAP_COUNT; g++) begin : g_cell
      assign cell_ctrl[g].shift   = acc_sample;
      assign cell_ctrl[g].coef_we = acc_load && (32'(req_coef_index) == g);
      assign cell_ctrl[g].tap_on  = (g == 0) || (32'(g) < 32'(tap_count_ff));

      fir16_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl[g]),
         .sample_in  (smp[g]),
         .coef_value (req_coef_value),
         .link_in    (link[g]),
         .sample_out (smp[g+1]),
         .link_out   (link[g+1])
      );
   end

   assign chain_tok = link[MAX_TAP_COUNT].tok;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // ---- control ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (emit) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (chain_tok) begin
               state_in = slot_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      load_out  = 1'b0;
      acc_sel   = link[MAX_TAP_COUNT].sum;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_SWEEP: begin
            load_out = chain_tok && slot_free;
         end
         ST_HOLD: begin
            load_out = slot_free;
            acc_sel  = hold_ff;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      output_sum_in = output_sum_ff;
      if (acc_start) begin
         output_sum_in = '0;
      end else if (load_out) begin
         output_sum_in = output_sum_ff + acc_sel;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         tap_count_ff  <= 6'd32;
         fill_ff       <= '0;
         launch_ff     <= 1'b0;
         output_sum_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         launch_ff     <= emit;
         output_sum_ff <= output_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            tap_count_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_SWEEP && chain_tok) begin
         hold_ff <= link[MAX_TAP_COUNT].sum;
      end
      if (load_out) begin
         filter_out_ff <= acc_sel;
         block_sum_ff  <= output_sum_ff + acc_sel;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_filter_out = filter_out_ff;
   assign rsp_block_sum  = block_sum_ff;

endmodule

// ===== design/fir16_checker.sv =====
// Port-level checks for the FIR filter unit, bound to its top level.
module fir16_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic [1:0]           req_func,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input fir16_pkg::acc_type    rsp_filter_out,
   input fir16_pkg::acc_type    rsp_block_sum
);
   import fir16_pkg::*;

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filter_out)
                                  && $stable(rsp_block_sum))
      else $error("stalled result changed or dropped");

   // loads, block starts and the unused code never start a sweep
   a_no_sweep: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_func != FUNC_SAMPLE) |=> !req_stall)
      else $error("non-sample item stalled the request side");

   // a new result only comes out of a sweep
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a sweep");

   // reset leaves the unit idle and empty
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("unit not idle after reset");

endmodule

bind fir_filter_int16_unit fir16_checker u_fir16_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_func       (req_func),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_filter_out (rsp_filter_out),
   .rsp_block_sum  (rsp_block_sum)
);

// ===== verif/fir_filter_int16_unit_tb.sv =====
// Self-checking testbench for the 16-bit FIR filter unit.
`timescale 1ns / 1ps

module fir_filter_int16_unit_tb;
   import fir16_pkg::*;

   localparam int TAPS_MAX = 32;
   // wait long enough for any sweep to finish before a csr write
   localparam int SETTLE_CYCLES = TAPS_MAX + 16;
   localparam int HOLD_CYCLES = 300;
   // func 3 carries no operation; the unit must ignore it
   localparam logic [1:0] FUNC_RESERVED = 2'd3;

   typedef struct {
      acc_type filter_out;
      acc_type block_sum;
   } filter_result_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_func;
   logic [4:0] req_coef_index;
   sample_type req_coef_value;
   sample_type req_sample_in;
   logic       rsp_valid;
   logic       rsp_stall;
   acc_type    rsp_filter_out;
   acc_type    rsp_block_sum;
   logic       csr_valid;
   logic       csr_ready;
   logic [5:0] csr_data;

   // shadow of the unit's state, kept by the predictor
   sample_type history [TAPS_MAX];
   sample_type coef_mem [TAPS_MAX];
   logic       coef_written [TAPS_MAX];
   int         fill_count;
   acc_type    block_total;
   logic [5:0] taps_setting;

   // filter results still owed by the unit, oldest first
   filter_result_type pending_outputs [$];

   int  fail_count = 0;
   int  items_sent = 0;
   int  results_checked = 0;
   int  settings_used = 0;
   bit  sender_idle_on = 1'b0;
   bit  receiver_idle_on = 1'b0;
   bit  hold_request = 1'b0;

   fir_filter_int16_unit #(
      .MAX_TAP_COUNT(TAPS_MAX)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_filter_out (rsp_filter_out),
      .rsp_block_sum  (rsp_block_sum),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   always #4 clock = ~clock;

   // tap_count of 0 behaves as 1, anything above the maximum as the maximum
   function automatic int taps_in_use(input logic [5:0] t);
      if (t == 6'd0)
         return 1;
      if (int'(t) > TAPS_MAX)
         return TAPS_MAX;
      return int'(t);
   endfunction

   // random sample, with the two extremes turning up often
   function automatic sample_type rand_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // Update the shadow state for one accepted item and queue any result.
   task automatic predict_filter(input logic [1:0] f, input logic [4:0] idx,
                                 input sample_type cv, input sample_type smp);
      int                i;
      int                taps;
      acc_type           sum;
      acc_type           prod;
      filter_result_type res;
      case (f)
         FUNC_LOAD: begin
            // a 5-bit index can never reach past the store
            coef_mem[idx] = cv;
            coef_written[idx] = 1'b1;
         end
         FUNC_START: begin
            fill_count = 0;
            block_total = '0;
         end
         FUNC_SAMPLE: begin
            for (i = TAPS_MAX - 1; i > 0; i--)
               history[i] = history[i - 1];
            history[0] = smp;
            if (fill_count < TAPS_MAX)
               fill_count++;
            taps = taps_in_use(taps_setting);
            // still warming up: no output
            if (fill_count >= taps) begin
               sum = '0;
               for (i = 0; i < taps; i++) begin
                  prod = history[i] * coef_mem[i];
                  sum = sum + prod;
               end
               block_total = block_total + sum;
               res.filter_out = sum;
               res.block_sum = block_total;
               pending_outputs.push_back(res);
            end
         end
         default: ;
      endcase
   endtask

   // Offer one item, hold it until accepted, then predict it.
   task automatic send_item(input logic [1:0] f, input logic [4:0] idx,
                            input sample_type cv, input sample_type smp);
      int gap;
      gap = 0;
      if (sender_idle_on && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_coef_index <= idx;
      req_coef_value <= cv;
      req_sample_in  <= smp;
      do
         @(posedge clock);
      while (req_stall);
      items_sent++;
      predict_filter(f, idx, cv, smp);
   endtask

   task automatic send_sample(input sample_type smp);
      send_item(FUNC_SAMPLE, 5'($urandom), sample_type'($urandom), smp);
   endtask

   // Mostly samples; loads, starts and the unused code mixed in.
   task automatic send_random_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)
         send_item(FUNC_RESERVED, 5'($urandom), rand_sample(), rand_sample());
      else if (r < 10)
         send_item(FUNC_START, 5'($urandom), rand_sample(), rand_sample());
      else if (r < 25)
         send_item(FUNC_LOAD, 5'($urandom), rand_sample(), rand_sample());
      else
         send_sample(rand_sample());
   endtask

   // Drop valid and wait for every owed result.
   task automatic drain_outputs();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outputs.size() != 0)
         @(posedge clock);
   endtask

   // Write tap_count once the unit is idle, then make sure every tap in use
   // has a coefficient before any sample reads it.
   task automatic write_taps(input logic [5:0] value);
      int i;
      drain_outputs();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      taps_setting = value;
      settings_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
      for (i = 0; i < taps_in_use(value); i++)
         if (!coef_written[i])
            send_item(FUNC_LOAD, 5'(i), rand_sample(), rand_sample());
   endtask

   // Field extremes, warm-up, wrap, ignored code and a block restart.
   task automatic test_directed();
      int i;
      send_item(FUNC_LOAD, 5'd0, 16'sh8000, 16'sh7FFF);
      send_item(FUNC_LOAD, 5'd1, 16'sh8000, 16'sh0000);
      send_item(FUNC_LOAD, 5'd2, 16'sh7FFF, 16'shFFFF);
      send_item(FUNC_LOAD, 5'd3, 16'sh8000, 16'sh8000);
      send_item(FUNC_LOAD, 5'd31, 16'sh7FFF, 16'sh0001);
      write_taps(6'd4);
      // full-scale negative samples against full-scale taps: sums wrap
      for (i = 0; i < 5; i++)
         send_sample(16'sh8000);
      send_item(FUNC_RESERVED, 5'd31, 16'sh7FFF, 16'sh7FFF);
      send_sample(16'sh7FFF);
      send_sample(16'sh0000);
      send_sample(16'shFFFF);
      // restart: history kept, warm-up and block_sum start over
      send_item(FUNC_START, 5'd0, 16'sh0000, 16'sh0000);
      for (i = 0; i < 4; i++)
         send_sample(rand_sample());
   endtask

   // tap_count raised above the fill level pauses results; lowered resumes.
   task automatic test_tap_change();
      int i;
      write_taps(6'd2);
      send_item(FUNC_START, 5'($urandom), rand_sample(), rand_sample());
      for (i = 0; i < 5; i++)
         send_sample(rand_sample());
      write_taps(6'd8);
      for (i = 0; i < 4; i++)
         send_sample(rand_sample());
      write_taps(6'd3);
      for (i = 0; i < 2; i++)
         send_sample(rand_sample());
   endtask

   // Receiver holds off for a long stretch while samples keep coming.
   task automatic test_backpressure();
      int i;
      write_taps(6'd3);
      sender_idle_on = 1'b0;
      hold_request = 1'b1;
      for (i = 0; i < 40; i++)
         send_sample(rand_sample());
      drain_outputs();
   endtask

   // Random streams across a spread of settings, extremes included.
   task automatic test_random_settings();
      logic [5:0] plan [8];
      int         p;
      int         n;
      plan = '{6'd1, 6'd0, 6'd63, 6'd32, 6'd2, 6'd33,
               6'($urandom_range(0, 63)), 6'($urandom_range(0, 63))};
      for (p = 0; p < 8; p++) begin
         // in some phases the sender or the receiver runs without idling
         sender_idle_on   = ($urandom_range(0, 3) != 0);
         receiver_idle_on = ($urandom_range(0, 3) != 0);
         write_taps(plan[p]);
         for (n = 0; n < 110; n++) begin
            if (n == 55 && $urandom_range(0, 1) == 0)
               drain_outputs();
            send_random_item();
         end
      end
   endtask

   // Final stretch at full rate on both sides.
   task automatic test_back_to_back();
      int n;
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      write_taps(6'($urandom_range(1, 32)));
      for (n = 0; n < 100; n++)
         send_random_item();
   endtask

   // Receiver: random stall bursts, or one long hold when asked.
   initial begin : receiver
      int burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_request = 1'b0;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(0, 14);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Compare each accepted result with the oldest owed one.
   always @(posedge clock) begin : check_output
      filter_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outputs.size() == 0) begin
            $error("unexpected result: filter_out %0d block_sum %0d",
                   rsp_filter_out, rsp_block_sum);
            fail_count++;
         end else begin
            want = pending_outputs.pop_front();
            results_checked++;
            if (rsp_filter_out !== want.filter_out) begin
               $error("filter_out mismatch: expected %0d, got %0d",
                      want.filter_out, rsp_filter_out);
               fail_count++;
            end
            if (rsp_block_sum !== want.block_sum) begin
               $error("block_sum mismatch: expected %0d, got %0d",
                      want.block_sum, rsp_block_sum);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d results still owed", pending_outputs.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_LOAD;
      req_coef_index = '0;
      req_coef_value = '0;
      req_sample_in  = '0;
      csr_valid      = 1'b0;
      csr_data       = '0;
      taps_setting   = 6'd32;
      fill_count     = 0;
      block_total    = '0;
      for (int i = 0; i < TAPS_MAX; i++) begin
         history[i]      = '0;
         coef_mem[i]     = '0;
         coef_written[i] = 1'b0;
      end
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
      test_directed();
      test_tap_change();
      test_backpressure();
      test_random_settings();
      test_back_to_back();

      drain_outputs();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d items across %0d tap_count settings, %0d filter results checked",
               items_sent, settings_used, results_checked);
      $display("Covered warm-up, restarts, ignored code, wrap, long hold-off, full rate");
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== fir_filter_int16_unit.f =====
design/fir16_pkg.sv
design/fir16_cell.sv
design/fir_filter_int16_unit.sv
design/fir16_checker.sv
verif/fir_filter_int16_unit_tb.sv
